// ----- hdl/id3v2_tag_frame_parser_unit_defines.svh -----
// ---------------------------------------------------------------------------
// id3v2 tag frame parser assertion macros
// shared concurrent check templates, clocked on i_clk, off while in reset
// ---------------------------------------------------------------------------
`ifndef ID3V2_TAG_FRAME_PARSER_UNIT_DEFINES_SVH
`define ID3V2_TAG_FRAME_PARSER_UNIT_DEFINES_SVH

// implication check: when ante holds, cons must hold in the same cycle
`define ID3_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("id3 parser check failed");

// next-cycle check: when ante holds, cons must hold in the next cycle
`define ID3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("id3 parser check failed");

`endif

// ----- hdl/id3_pkg.sv -----
// ---------------------------------------------------------------------------
// id3 parser package
// shared types, codes and the frame id lookup for the tag frame parser
// ---------------------------------------------------------------------------
package id3_pkg;

    // parse phases
    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_EXT     = 3'd1,
        PH_SKIP    = 3'd2,
        PH_FRAME   = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    // result kinds
    typedef enum logic [1:0] {
        KIND_TAG_HDR  = 2'd0,
        KIND_EXT_SIZE = 2'd1,
        KIND_PAYLOAD  = 2'd2,
        KIND_END      = 2'd3
    } t_kind;

    // frame categories
    localparam logic [2:0] CAT_ARTIST  = 3'd0;
    localparam logic [2:0] CAT_ALBUM   = 3'd1;
    localparam logic [2:0] CAT_TITLE   = 3'd2;
    localparam logic [2:0] CAT_YEAR    = 3'd3;
    localparam logic [2:0] CAT_GENRE   = 3'd4;
    localparam logic [2:0] CAT_TRACK   = 3'd5;
    localparam logic [2:0] CAT_PRIVATE = 3'd6;

    // frame ids, first character in the top byte
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;
    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TYER = 32'h5459_4552;
    localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
    localparam logic [31:0] ID_TRCK = 32'h5452_434B;
    localparam logic [31:0] ID_PRIV = 32'h5052_4956;

    // header field layout
    localparam logic [7:0]  EXT_FLAG      = 8'h40;
    localparam logic [3:0]  HDR_LAST_IDX  = 4'd9;
    localparam logic [3:0]  EXT_LAST_IDX  = 4'd5;
    localparam logic [27:0] EXT_HDR_BYTES = 28'd6;

    // one result as it leaves the parse core
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [2:0]  category;
        logic [7:0]  payload_byte;
        logic [27:0] size_value;
        logic [7:0]  tag_version;
        logic [7:0]  tag_revision;
        logic        last_of_frame;
    } t_result;

    // frame id to {hit, category}
    function automatic logic [3:0] id_category(input logic [31:0] id);
        logic [3:0] r;
        r = 4'b0000;
        case (id)
            ID_TPE1: r = {1'b1, CAT_ARTIST};
            ID_TALB: r = {1'b1, CAT_ALBUM};
            ID_TIT2: r = {1'b1, CAT_TITLE};
            ID_TYER: r = {1'b1, CAT_YEAR};
            ID_TCON: r = {1'b1, CAT_GENRE};
            ID_TRCK: r = {1'b1, CAT_TRACK};
            ID_PRIV: r = {1'b1, CAT_PRIVATE};
            default: r = 4'b0000;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/id3_in_stage.sv -----
// ---------------------------------------------------------------------------
// id3 input stage
// input register holding one byte transaction until the core takes it
// ---------------------------------------------------------------------------
module id3_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_restart,
    input  logic       i_take,
    output logic       o_full,
    output logic [7:0] o_byte,
    output logic       o_restart
);
    import id3_pkg::*;

    logic       r_full;
    logic [7:0] r_byte;
    logic       r_restart;

    // hold off only while a byte sits here and the core cannot take it
    assign o_stall = r_full && !i_take;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (!o_stall) begin
            r_full <= i_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte    <= i_data_byte;
            r_restart <= i_restart;
        end
    end

    assign o_full    = r_full;
    assign o_byte    = r_byte;
    assign o_restart = r_restart;

endmodule

// ----- hdl/id3_parse_core.sv -----
// ---------------------------------------------------------------------------
// id3 parse core
// parser state and the single-pass per-byte step logic
// ---------------------------------------------------------------------------
`include "id3v2_tag_frame_parser_unit_defines.svh"

module id3_parse_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_restart,
    output id3_pkg::t_result o_res
);
    import id3_pkg::*;

    t_phase      r_phase, n_phase, e_phase;
    logic [3:0]  r_count, n_count, e_count;
    logic [27:0] r_acc, n_acc, e_acc;
    logic [31:0] r_id, n_id, e_id;
    logic [27:0] r_rem, n_rem, e_rem;
    logic [7:0]  r_ver, n_ver, e_ver;
    logic [7:0]  r_rev, n_rev, e_rev;
    logic [7:0]  r_flags, n_flags, e_flags;
    logic [2:0]  r_cat, n_cat, e_cat;

    logic [27:0] w_acc_first;
    logic [27:0] w_acc_shift;
    logic [27:0] w_rem_dec;
    logic [27:0] w_ext_rem;
    logic [3:0]  w_lookup;

    // restart clears the state seen by this byte
    always_comb begin
        e_phase = i_restart ? PH_TAG : r_phase;
        e_count = i_restart ? 4'd0   : r_count;
        e_acc   = i_restart ? 28'd0  : r_acc;
        e_id    = i_restart ? 32'd0  : r_id;
        e_rem   = i_restart ? 28'd0  : r_rem;
        e_ver   = i_restart ? 8'd0   : r_ver;
        e_rev   = i_restart ? 8'd0   : r_rev;
        e_flags = i_restart ? 8'd0   : r_flags;
        e_cat   = i_restart ? 3'd0   : r_cat;
    end

    // synchsafe assembly, down-counter and frame lookup
    assign w_acc_first = {21'd0, i_byte[6:0]};
    assign w_acc_shift = {e_acc[20:0], i_byte[6:0]};
    assign w_rem_dec   = (e_rem != 28'd0) ? e_rem - 28'd1 : 28'd0;
    assign w_ext_rem   = (e_acc > EXT_HDR_BYTES) ? e_acc - EXT_HDR_BYTES : 28'd0;
    assign w_lookup    = id_category(e_id);

    // next phase
    always_comb begin
        n_phase = e_phase;
        case (e_phase)
            PH_TAG: begin
                if (e_count >= HDR_LAST_IDX) begin
                    n_phase = (e_flags == EXT_FLAG) ? PH_EXT : PH_FRAME;
                end
            end
            PH_EXT: begin
                if (e_count >= EXT_LAST_IDX) begin
                    n_phase = (w_ext_rem != 28'd0) ? PH_SKIP : PH_FRAME;
                end
            end
            PH_SKIP: begin
                if (w_rem_dec == 28'd0) begin
                    n_phase = PH_FRAME;
                end
            end
            PH_FRAME: begin
                if (e_count >= HDR_LAST_IDX) begin
                    if (!w_lookup[3]) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = (e_acc != 28'd0) ? PH_PAYLOAD : PH_FRAME;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (w_rem_dec == 28'd0) begin
                    n_phase = PH_FRAME;
                end
            end
            default: begin
                n_phase = e_phase;
            end
        endcase
    end

    // datapath updates and result
    always_comb begin
        n_count = e_count;
        n_acc   = e_acc;
        n_id    = e_id;
        n_rem   = e_rem;
        n_ver   = e_ver;
        n_rev   = e_rev;
        n_flags = e_flags;
        n_cat   = e_cat;
        o_res   = '0;
        case (e_phase)
            PH_TAG: begin
                if (e_count == 4'd3) n_ver = i_byte;
                else if (e_count == 4'd4) n_rev = i_byte;
                else if (e_count == 4'd5) n_flags = i_byte;
                else if (e_count == 4'd6) n_acc = w_acc_first;
                else if (e_count > 4'd6) n_acc = w_acc_shift;
                if (e_count >= HDR_LAST_IDX) begin
                    n_count            = 4'd0;
                    o_res.valid        = 1'b1;
                    o_res.kind         = KIND_TAG_HDR;
                    o_res.size_value   = n_acc;
                    o_res.tag_version  = n_ver;
                    o_res.tag_revision = n_rev;
                end else begin
                    n_count = e_count + 4'd1;
                end
            end
            PH_EXT: begin
                if (e_count == 4'd0) n_acc = w_acc_first;
                else if (e_count < 4'd4) n_acc = w_acc_shift;
                if (e_count >= EXT_LAST_IDX) begin
                    n_count          = 4'd0;
                    n_rem            = w_ext_rem;
                    o_res.valid      = 1'b1;
                    o_res.kind       = KIND_EXT_SIZE;
                    o_res.size_value = e_acc;
                end else begin
                    n_count = e_count + 4'd1;
                end
            end
            PH_SKIP: begin
                n_rem = w_rem_dec;
            end
            PH_FRAME: begin
                if (e_count < 4'd4) n_id = {e_id[23:0], i_byte};
                else if (e_count == 4'd4) n_acc = w_acc_first;
                else if (e_count < 4'd8) n_acc = w_acc_shift;
                if (e_count >= HDR_LAST_IDX) begin
                    n_count = 4'd0;
                    if (w_lookup[3]) begin
                        n_cat = w_lookup[2:0];
                        n_rem = e_acc;
                    end else begin
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_END;
                    end
                end else begin
                    n_count = e_count + 4'd1;
                end
            end
            PH_PAYLOAD: begin
                n_rem               = w_rem_dec;
                o_res.valid         = 1'b1;
                o_res.kind          = KIND_PAYLOAD;
                o_res.category      = e_cat;
                o_res.payload_byte  = i_byte;
                o_res.last_of_frame = (w_rem_dec == 28'd0);
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

    // state registers, advanced once per byte taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_count <= 4'd0;
            r_acc   <= 28'd0;
            r_id    <= 32'd0;
            r_rem   <= 28'd0;
            r_ver   <= 8'd0;
            r_rev   <= 8'd0;
            r_flags <= 8'd0;
            r_cat   <= 3'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_acc   <= n_acc;
            r_id    <= n_id;
            r_rem   <= n_rem;
            r_ver   <= n_ver;
            r_rev   <= n_rev;
            r_flags <= n_flags;
            r_cat   <= n_cat;
        end
    end

    // checks
    `ID3_ASSERT_IMPL(a_done_silent, r_phase == PH_DONE && !i_restart, !o_res.valid)
    `ID3_ASSERT_IMPL(a_count_range, 1'b1, r_count <= HDR_LAST_IDX)
    `ID3_ASSERT_NEXT(a_end_to_done, i_step && o_res.valid && o_res.kind == KIND_END,
                     r_phase == PH_DONE)

endmodule

// ----- hdl/id3_out_stage.sv -----
// ---------------------------------------------------------------------------
// id3 output stage
// result register decoupling the core from the downstream stall
// ---------------------------------------------------------------------------
module id3_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  id3_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_open,
    output logic             o_valid,
    output logic [1:0]       o_result_kind,
    output logic [2:0]       o_category,
    output logic [7:0]       o_payload_byte,
    output logic [27:0]      o_size_value,
    output logic [7:0]       o_tag_version,
    output logic [7:0]       o_tag_revision,
    output logic             o_last_of_frame
);
    import id3_pkg::*;

    logic    r_valid;
    t_result r_res;

    // room for a new result when empty or being drained now
    assign o_open = !r_valid || !i_stall;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res.valid;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid         = r_valid;
    assign o_result_kind   = r_res.kind;
    assign o_category      = r_res.category;
    assign o_payload_byte  = r_res.payload_byte;
    assign o_size_value    = r_res.size_value;
    assign o_tag_version   = r_res.tag_version;
    assign o_tag_revision  = r_res.tag_revision;
    assign o_last_of_frame = r_res.last_of_frame;

endmodule

// ----- hdl/id3v2_tag_frame_parser_unit.sv -----
// ---------------------------------------------------------------------------
// id3v2 tag frame parser unit
// byte-wide tag and frame header parser with an input and a result register
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  input   | in        | i_valid / o_stall   | i_data_byte, i_restart
//  result  | out       | o_valid / i_stall   | o_result_kind .. o_last_of_frame
//
//  one byte transaction per cycle sustained while i_stall stays low; a byte's result
//  is registered as the byte steps out of the input register, and leaves when i_stall is low
//  the parse step is a single pass of logic between the two registers
//  reset is synchronous, active low, and empties both registers
//  a downstream stall holds the result register; the input stalls only when
//  a byte is waiting and the result register cannot take its result
// ---------------------------------------------------------------------------
`include "id3v2_tag_frame_parser_unit_defines.svh"

module id3v2_tag_frame_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_category,
    output logic [7:0]  o_payload_byte,
    output logic [27:0] o_size_value,
    output logic [7:0]  o_tag_version,
    output logic [7:0]  o_tag_revision,
    output logic        o_last_of_frame
);
    import id3_pkg::*;

    logic       w_full;
    logic [7:0] w_byte;
    logic       w_restart;
    logic       w_open;
    logic       w_step;
    t_result    w_res;

    // a byte steps through the core when the result register has room
    assign w_step = w_full && w_open;

    // input register
    id3_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_restart   (i_restart),
        .i_take      (w_step),
        .o_full      (w_full),
        .o_byte      (w_byte),
        .o_restart   (w_restart)
    );

    // parser state and step logic
    id3_parse_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_byte    (w_byte),
        .i_restart (w_restart),
        .o_res     (w_res)
    );

    // result register
    id3_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_step),
        .i_res           (w_res),
        .i_stall         (i_stall),
        .o_open          (w_open),
        .o_valid         (o_valid),
        .o_result_kind   (o_result_kind),
        .o_category      (o_category),
        .o_payload_byte  (o_payload_byte),
        .o_size_value    (o_size_value),
        .o_tag_version   (o_tag_version),
        .o_tag_revision  (o_tag_revision),
        .o_last_of_frame (o_last_of_frame)
    );

    // checks
    `ID3_ASSERT_IMPL(a_no_stall_when_open, !o_valid, !o_stall)
    `ID3_ASSERT_IMPL(a_payload_fields,
                     o_valid && o_result_kind == KIND_PAYLOAD,
                     o_size_value == 28'd0 && o_tag_version == 8'd0)
    `ID3_ASSERT_IMPL(a_last_only_payload,
                     o_valid && o_result_kind != KIND_PAYLOAD,
                     !o_last_of_frame && o_payload_byte == 8'd0)

endmodule

// ----- dv/id3v2_tag_frame_parser_checker.sv -----
// ---------------------------------------------------------------------------
// id3v2 tag frame parser checker
// watches both channels of the parser, runs a byte-level model of the tag,
// extended header and frame parse, and compares every result transaction
// ---------------------------------------------------------------------------
module id3v2_tag_frame_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [1:0]  o_result_kind,
    input  logic [2:0]  o_category,
    input  logic [7:0]  o_payload_byte,
    input  logic [27:0] o_size_value,
    input  logic [7:0]  o_tag_version,
    input  logic [7:0]  o_tag_revision,
    input  logic        o_last_of_frame,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_byte_count,
    output int          o_hdr_count,
    output int          o_ext_count,
    output int          o_payload_count,
    output int          o_end_count
);
    import id3_pkg::*;

    // one predicted result
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  category;
        logic [7:0]  payload_byte;
        logic [27:0] size_value;
        logic [7:0]  tag_version;
        logic [7:0]  tag_revision;
        logic        last_of_frame;
    } t_parse_result;

    // model state
    t_phase      phase;
    logic [3:0]  field_idx;
    logic [27:0] size_acc;
    logic [31:0] id_shift;
    logic [27:0] remaining;
    logic [7:0]  version_q;
    logic [7:0]  revision_q;
    logic [7:0]  flags_q;
    logic [2:0]  category_q;

    t_parse_result result_q[$];
    t_parse_result next_result;
    int            result_idx = 0;

    function automatic void clear_parse_state();
        phase      = PH_TAG;
        field_idx  = '0;
        size_acc   = '0;
        id_shift   = '0;
        remaining  = '0;
        version_q  = '0;
        revision_q = '0;
        flags_q    = '0;
        category_q = '0;
    endfunction

    // frame id lookup, returns 1 on a known id
    function automatic bit known_frame(input logic [31:0] id, output logic [2:0] cat);
        cat = CAT_ARTIST;
        if (id == ID_TPE1) cat = CAT_ARTIST;
        else if (id == ID_TALB) cat = CAT_ALBUM;
        else if (id == ID_TIT2) cat = CAT_TITLE;
        else if (id == ID_TYER) cat = CAT_YEAR;
        else if (id == ID_TCON) cat = CAT_GENRE;
        else if (id == ID_TRCK) cat = CAT_TRACK;
        else if (id == ID_PRIV) cat = CAT_PRIVATE;
        else return 1'b0;
        return 1'b1;
    endfunction

    // advance the parse by one byte, returns 1 when a result is due
    function automatic bit parse_byte(input logic [7:0] b, input logic restart,
                                      output t_parse_result r);
        logic [2:0] cat;
        r = '0;
        if (restart) clear_parse_state();
        case (phase)
            PH_TAG: begin
                if (field_idx == 4'd3) version_q = b;
                else if (field_idx == 4'd4) revision_q = b;
                else if (field_idx == 4'd5) flags_q = b;
                else if (field_idx == 4'd6) size_acc = {21'd0, b[6:0]};
                else if (field_idx > 4'd6) size_acc = {size_acc[20:0], b[6:0]};
                if (field_idx >= HDR_LAST_IDX) begin
                    field_idx = '0;
                    phase = (flags_q == EXT_FLAG) ? PH_EXT : PH_FRAME;
                    r.kind = KIND_TAG_HDR;
                    r.size_value = size_acc;
                    r.tag_version = version_q;
                    r.tag_revision = revision_q;
                    return 1'b1;
                end
                field_idx++;
                return 1'b0;
            end
            PH_EXT: begin
                if (field_idx == 4'd0) size_acc = {21'd0, b[6:0]};
                else if (field_idx < 4'd4) size_acc = {size_acc[20:0], b[6:0]};
                if (field_idx >= EXT_LAST_IDX) begin
                    field_idx = '0;
                    remaining = (size_acc > EXT_HDR_BYTES) ? size_acc - EXT_HDR_BYTES : '0;
                    phase = (remaining != 0) ? PH_SKIP : PH_FRAME;
                    r.kind = KIND_EXT_SIZE;
                    r.size_value = size_acc;
                    return 1'b1;
                end
                field_idx++;
                return 1'b0;
            end
            PH_SKIP: begin
                if (remaining != 0) remaining--;
                if (remaining == 0) phase = PH_FRAME;
                return 1'b0;
            end
            PH_FRAME: begin
                if (field_idx < 4'd4) id_shift = {id_shift[23:0], b};
                else if (field_idx == 4'd4) size_acc = {21'd0, b[6:0]};
                else if (field_idx < 4'd8) size_acc = {size_acc[20:0], b[6:0]};
                if (field_idx >= HDR_LAST_IDX) begin
                    field_idx = '0;
                    if (!known_frame(id_shift, cat)) begin
                        phase = PH_DONE;
                        r.kind = KIND_END;
                        return 1'b1;
                    end
                    category_q = cat;
                    remaining = size_acc;
                    phase = (remaining != 0) ? PH_PAYLOAD : PH_FRAME;
                    return 1'b0;
                end
                field_idx++;
                return 1'b0;
            end
            PH_PAYLOAD: begin
                if (remaining != 0) remaining--;
                if (remaining == 0) phase = PH_FRAME;
                r.kind = KIND_PAYLOAD;
                r.category = category_q;
                r.payload_byte = b;
                r.last_of_frame = (remaining == 0);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // print one line per failure and count it
    task automatic report_failure(input string msg);
        $display("check failed: %s", msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string field, input logic [27:0] want,
                               input logic [27:0] got);
        if (got !== want)
            report_failure($sformatf("result %0d %s expected 0x%0h got 0x%0h",
                                     result_idx, field, want, got));
    endtask

    task automatic compare_result(input t_parse_result want);
        check_field("kind", 28'(want.kind), 28'(o_result_kind));
        check_field("category", 28'(want.category), 28'(o_category));
        check_field("payload_byte", 28'(want.payload_byte), 28'(o_payload_byte));
        check_field("size_value", want.size_value, o_size_value);
        check_field("tag_version", 28'(want.tag_version), 28'(o_tag_version));
        check_field("tag_revision", 28'(want.tag_revision), 28'(o_tag_revision));
        check_field("last_of_frame", 28'(want.last_of_frame), 28'(o_last_of_frame));
    endtask

    // transaction monitor: results first, then the byte taken at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse_state();
            result_q.delete();
        end else begin
            if (o_valid && !i_stall) begin
                case (o_result_kind)
                    KIND_TAG_HDR:  o_hdr_count++;
                    KIND_EXT_SIZE: o_ext_count++;
                    KIND_PAYLOAD:  o_payload_count++;
                    default:       o_end_count++;
                endcase
                if (result_q.size() == 0)
                    report_failure($sformatf("result %0d kind %0d with nothing expected",
                                             result_idx, o_result_kind));
                else
                    compare_result(result_q.pop_front());
                result_idx++;
            end
            if (i_valid && !o_stall) begin
                o_byte_count++;
                if (parse_byte(i_data_byte, i_restart, next_result))
                    result_q.push_back(next_result);
            end
        end
        o_pending <= result_q.size();
    end

endmodule

// ----- dv/id3v2_tag_frame_parser_unit_tb.sv -----
// ---------------------------------------------------------------------------
// id3v2 tag frame parser unit testbench
// streams directed and random tagged files byte by byte, with broken files
// and noise mixed in, under varying idle and stall patterns; a checker
// beside the unit predicts and compares every result
// ---------------------------------------------------------------------------
module id3v2_tag_frame_parser_unit_tb;
    import id3_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int STREAM_BYTES = 820;
    localparam logic [31:0] KNOWN_IDS [7] = '{ID_TPE1, ID_TALB, ID_TIT2, ID_TYER,
                                             ID_TCON, ID_TRCK, ID_PRIV};

    typedef struct packed {
        logic [7:0] b;
        logic       rs;
    } t_stream_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_restart = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [2:0]  o_category;
    logic [7:0]  o_payload_byte;
    logic [27:0] o_size_value;
    logic [7:0]  o_tag_version;
    logic [7:0]  o_tag_revision;
    logic        o_last_of_frame;

    int fail_count;
    int pending;
    int byte_count;
    int hdr_count;
    int ext_count;
    int payload_count;
    int end_count;

    int   recv_pct = 0;
    logic stim_done = 1'b0;
    int   file_count = 0;

    t_stream_byte stream_q[$];
    t_stream_byte file_q[$];

    id3v2_tag_frame_parser_unit uut (.*);

    id3v2_tag_frame_parser_checker chk (
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_byte_count   (byte_count),
        .o_hdr_count    (hdr_count),
        .o_ext_count    (ext_count),
        .o_payload_count(payload_count),
        .o_end_count    (end_count),
        .*
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < recv_pct);
    end

    task automatic put_byte(input logic [7:0] b);
        t_stream_byte sb;
        sb.b = b;
        sb.rs = 1'b0;
        file_q.push_back(sb);
    endtask

    // four 7-bit groups, msb first; junk sets the unused top bits at random
    task automatic put_synchsafe(input logic [27:0] value, input bit junk);
        logic [7:0] b;
        for (int k = 3; k >= 0; k--) begin
            b = {1'b0, value[k*7 +: 7]};
            if (junk) b[7] = 1'($urandom_range(1));
            put_byte(b);
        end
    endtask

    task automatic put_frame(input logic [31:0] id, input logic [27:0] size, input int n_payload);
        for (int k = 3; k >= 0; k--) put_byte(id[k*8 +: 8]);
        put_synchsafe(size, 1'b1);
        put_byte(8'($urandom));
        put_byte(8'($urandom));
        repeat (n_payload) put_byte(8'($urandom));
    endtask

    // move the file into the stream, optionally cut short
    task automatic commit_file(input bit cut);
        int keep;
        t_stream_byte sb;
        keep = file_q.size();
        if (cut && keep > 1) keep = $urandom_range(keep - 1, 1);
        for (int k = 0; k < keep; k++) begin
            sb = file_q[k];
            sb.rs = (k == 0);
            stream_q.push_back(sb);
        end
        file_q.delete();
        file_count++;
    endtask

    task automatic build_random_file();
        logic [7:0]  flags;
        logic [27:0] size;
        logic [31:0] id;
        int          pick;
        int          n_pay;
        bit          cut;
        cut = ($urandom_range(7) == 0);
        repeat (3) put_byte(8'($urandom));
        put_byte(8'($urandom));
        put_byte(8'($urandom));
        pick = $urandom_range(9);
        if (pick < 5) flags = EXT_FLAG;
        else if (pick == 5) flags = EXT_FLAG ^ (8'h01 << $urandom_range(7));
        else flags = 8'($urandom);
        put_byte(flags);
        put_synchsafe(28'($urandom), 1'b1);
        // extended header and skipped bytes
        if (flags == EXT_FLAG) begin
            pick = $urandom_range(9);
            if (pick < 7) size = 28'($urandom_range(14));
            else if (pick < 9) size = 28'($urandom_range(40, 15));
            else size = 28'($urandom);
            put_synchsafe(size, 1'b1);
            put_byte(8'($urandom));
            put_byte(8'($urandom));
            if (size > EXT_HDR_BYTES) begin
                if (size - EXT_HDR_BYTES > 40) begin
                    repeat ($urandom_range(8, 1)) put_byte(8'($urandom));
                    cut = 1'b1;
                end else begin
                    repeat (size - EXT_HDR_BYTES) put_byte(8'($urandom));
                end
            end
        end
        // known frames
        repeat ($urandom_range(5)) begin
            if (!cut) begin
                id = KNOWN_IDS[$urandom_range(6)];
                pick = $urandom_range(9);
                if (pick < 6) size = 28'($urandom_range(6));
                else if (pick < 9) size = 28'($urandom_range(30, 7));
                else size = 28'($urandom);
                n_pay = int'(size);
                if (size > 30) begin
                    n_pay = $urandom_range(10, 2);
                    cut = 1'b1;
                end
                put_frame(id, size, n_pay);
            end
        end
        // closing frame: padding, unknown id, or none
        pick = $urandom_range(5);
        if (!cut && pick < 2) begin
            put_frame(32'h0, 28'd0, 0);
            repeat ($urandom_range(4)) put_byte(8'($urandom));
        end else if (!cut && pick < 4) begin
            if (pick == 2) id = KNOWN_IDS[$urandom_range(6)] ^ (32'h1 << $urandom_range(31));
            else id = $urandom;
            put_frame(id, 28'($urandom), $urandom_range(4));
        end
        commit_file(cut);
    endtask

    task automatic build_noise(input int n);
        t_stream_byte sb;
        repeat (n) begin
            sb.b = 8'($urandom);
            sb.rs = ($urandom_range(7) == 0);
            stream_q.push_back(sb);
        end
    endtask

    // stimulus: directed file, then random files and noise, then the drain
    initial begin
        int send_pct;
        int total;

        // directed: extreme header bytes, short extended header,
        // empty known frame, one-byte frame, padding end, ignored tail
        put_byte(8'h49);
        put_byte(8'h44);
        put_byte(8'h33);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(EXT_FLAG);
        repeat (4) put_byte(8'hFF);
        put_synchsafe(EXT_HDR_BYTES, 1'b0);
        put_byte(8'h01);
        put_byte(8'hFF);
        put_frame(ID_TIT2, 28'd0, 0);
        put_frame(ID_PRIV, 28'd1, 1);
        put_frame(32'h0, 28'd0, 0);
        put_byte(8'hA5);
        commit_file(1'b0);

        while (stream_q.size() < STREAM_BYTES) begin
            if ($urandom_range(9) == 0) build_noise($urandom_range(20, 4));
            else build_random_file();
        end
        total = stream_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < total; n++) begin
            // idling: sender light/receiver heavy, then swapped, then none
            case (n * 3 / total)
                0: begin send_pct = 13; recv_pct <= 85; end
                1: begin send_pct = 85; recv_pct <= 13; end
                default: begin send_pct = 0; recv_pct <= 0; end
            endcase
            while ($urandom_range(99) < send_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data_byte <= stream_q[n].b;
            i_restart <= stream_q[n].rs;
            do @(posedge i_clk); while (o_stall);
        end
        i_valid <= 1'b0;
        stim_done <= 1'b1;

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("run: %0d bytes in %0d files and noise runs", byte_count, file_count);
        $display("results: %0d tag headers, %0d extended sizes, %0d payload bytes, %0d ends",
                 hdr_count, ext_count, payload_count, end_count);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog: no transaction for too long while work is outstanding
    initial begin
        int quiet;
        quiet = 0;
        @(posedge i_clk iff i_rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (stim_done && pending == 0))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction in %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending);
        $display("status: fail");
        $finish;
    end

endmodule

// ----- id3v2_tag_frame_parser_unit.f -----
+incdir+hdl
hdl/id3_pkg.sv
hdl/id3_in_stage.sv
hdl/id3_parse_core.sv
hdl/id3_out_stage.sv
hdl/id3v2_tag_frame_parser_unit.sv
dv/id3v2_tag_frame_parser_checker.sv
dv/id3v2_tag_frame_parser_unit_tb.sv
